// File: rtl/shs_pkg.sv
// Package with shared constants and types for the string hash set.
package shs_pkg;

   localparam int MaxSlotsDefault   = 1024;
   localparam int StartSlotsDefault = 8;
   localparam int MaxKeyCharsDefault = 8;
   localparam logic [7:0] MultReset = 8'd71;

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_CHECK = 2'd1;
   localparam logic [1:0] FUNC_DEL   = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   localparam logic [1:0] ST_EMPTY = 2'd0;
   localparam logic [1:0] ST_LIVE  = 2'd1;
   localparam logic [1:0] ST_TOMB  = 2'd2;

   typedef struct packed {
      logic [3:0] len;
      logic [1:0] status;
   } meta_type;

   typedef struct packed {
      logic       start;
      logic [63:0] key;
      logic [3:0] len;
      logic [7:0] mult;
   } hash_req_type;

endpackage

// File: rtl/shs_hash.sv
// Iterative Horner hash unit: one key byte per cycle.
module shs_hash
   import shs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hash_req_type hreq,
   output logic         done,
   output logic [63:0]  hash
);

   logic [63:0] h_ff, h_in;
   logic [63:0] key_ff, key_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [7:0]  mult_ff, mult_in;
   logic        busy_ff, busy_in;
   logic [71:0] prod;

   assign prod = h_ff * mult_ff;

   always_comb begin
      h_in = h_ff;
      key_in = key_ff;
      cnt_in = cnt_ff;
      mult_in = mult_ff;
      busy_in = busy_ff;
      if (hreq.start) begin
         h_in = '0;
         key_in = hreq.key;
         cnt_in = hreq.len;
         mult_in = hreq.mult;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            h_in = prod[63:0] + {56'd0, key_ff[7:0]};
            key_in = {8'd0, key_ff[63:8]};
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   assign done = busy_ff && (cnt_ff == 4'd0);
   assign hash = h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      h_ff <= h_in;
      key_ff <= key_in;
      cnt_ff <= cnt_in;
      mult_ff <= mult_in;
   end

endmodule

// File: rtl/shs_table.sv
// Two banks of slot storage, each a key memory and a metadata memory.
module shs_table
   import shs_pkg::*;
#(
   parameter int MaxSlots = MaxSlotsDefault,
   localparam int AW = $clog2(MaxSlots)
)
(
   input  logic          clock,
   input  logic          bank,
   input  logic [AW-1:0] rd_addr,
   output logic [63:0]   rd_key,
   output meta_type      rd_meta,
   input  logic          wr_en,
   input  logic          wr_bank,
   input  logic [AW-1:0] wr_addr,
   input  logic [63:0]   wr_key,
   input  meta_type      wr_meta
);

   logic [63:0] keys0 [MaxSlots];
   logic [63:0] keys1 [MaxSlots];
   meta_type    meta0 [MaxSlots];
   meta_type    meta1 [MaxSlots];
   logic [63:0] k0_ff, k1_ff;
   meta_type    m0_ff, m1_ff;
   logic        bank_ff;

   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) begin
         keys0[wr_addr] <= wr_key;
         meta0[wr_addr] <= wr_meta;
      end
      k0_ff <= keys0[rd_addr];
      m0_ff <= meta0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) begin
         keys1[wr_addr] <= wr_key;
         meta1[wr_addr] <= wr_meta;
      end
      k1_ff <= keys1[rd_addr];
      m1_ff <= meta1[rd_addr];
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank;
   end

   assign rd_key = bank_ff ? k1_ff : k0_ff;
   assign rd_meta = bank_ff ? m1_ff : m0_ff;

endmodule

// File: rtl/string_hash_set_open_addressing.sv
// Top level of the open-addressed string hash set with triangular probing.
// One transaction is taken at a time. After reset the block clears the metadata
// of the first StartSlots slots, with req_stall high. A transaction without
// growth is hashed key byte by key byte, then each probed slot is read and
// checked, and the response follows; the next one is accepted only once that
// response has been issued. The serial Horner hash unit (one byte per cycle)
// and the registered read of the slot memory shape these steps. An add that
// triggers a doubling first clears the spare bank over the new size, one slot
// per cycle, then rehashes every live key of the old table into it, each old
// slot being read and checked and each live key hashed and probed; a final
// state swaps the banks, without any copy, before the add itself.
module string_hash_set_open_addressing
   import shs_pkg::*;
#(
   parameter int MaxSlots    = MaxSlotsDefault,
   parameter int StartSlots  = StartSlotsDefault,
   parameter int MaxKeyChars = MaxKeyCharsDefault
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_key_chars,
   input  logic [3:0]  req_key_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_ok,
   output logic        rsp_table_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_hash_multiplier
);

   localparam int AW = $clog2(MaxSlots);
   localparam int SW = AW + 1;
   localparam int CW = SW + 2;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_HASH  = 13'b0000000000010,
      S_PRD   = 13'b0000000000100,
      S_PCHK  = 13'b0000000001000,
      S_DONE  = 13'b0000000010000,
      S_GRD   = 13'b0000000100000,
      S_GCHK  = 13'b0000001000000,
      S_GHASH = 13'b0000010000000,
      S_GPRD  = 13'b0000100000000,
      S_GPCHK = 13'b0001000000000,
      S_RESP  = 13'b0010000000000,
      S_INIT  = 13'b0100000000000,
      S_GCLR  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [7:0]    mult_ff;
   logic [1:0]    func_ff, func_in;
   logic [63:0]   key_ff, key_in;
   logic [3:0]    len_ff, len_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          bank_ff, bank_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [SW-1:0] step_ff, step_in;
   logic          tomb_ok_ff, tomb_ok_in;
   logic [AW-1:0] tomb_ff, tomb_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [63:0]   gkey_ff, gkey_in;
   logic [3:0]    glen_ff, glen_in;
   logic          ok_ff, ok_in, full_ff, full_in;
   logic          rok_ff, rok_in, rfull_ff, rfull_in;
   logic          rv_ff, rv_in;

   hash_req_type  hreq;
   logic          hdone;
   logic [63:0]   hval;
   logic [AW-1:0] rd_addr;
   logic [63:0]   rd_key;
   meta_type      rd_meta;
   logic          wr_en, wr_bank;
   logic [AW-1:0] wr_addr;
   logic [63:0]   wr_key;
   meta_type      wr_meta;
   logic [3:0]    len_sat;
   logic [63:0]   key_mask;
   logic [SW:0]   nxt_sum;
   logic [SW-1:0] nxt_idx, nsize;
   logic [SW-1:0] size_mask;
   logic [SW-1:0] wsize;
   logic          rd_spare;

   assign len_sat = (req_key_length > 4'(MaxKeyChars)) ? 4'(MaxKeyChars) : req_key_length;
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         key_mask[8*b +: 8] = (4'(b) < len_sat) ? 8'hFF : 8'h00;
      end
   end

   assign nsize = ((size_ff << 1) > SW'(MaxSlots)) ? SW'(MaxSlots) : (size_ff << 1);
   // Sizes are powers of two when StartSlots and MaxSlots are.
   assign wsize = (state_ff == S_GPRD || state_ff == S_GPCHK || state_ff == S_GHASH) ?
                  nsize : size_ff;
   assign size_mask = wsize - SW'(1);
   assign nxt_sum = {1'b0, SW'(idx_ff)} + {1'b0, step_ff};
   assign nxt_idx = (nxt_sum >= {1'b0, wsize}) ? SW'(nxt_sum - {1'b0, wsize}) : SW'(nxt_sum);

   // During regrowth the probe reads target the spare bank.
   assign rd_spare = (state_ff == S_GPRD);

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rv_ff;
   assign rsp_ok = rok_ff;
   assign rsp_table_full = rfull_ff;

   shs_hash u_hash (
      .clock(clock), .reset(reset), .hreq(hreq), .done(hdone), .hash(hval)
   );

   shs_table #(.MaxSlots(MaxSlots)) u_table (
      .clock(clock), .bank(bank_ff ^ rd_spare), .rd_addr(rd_addr),
      .rd_key(rd_key), .rd_meta(rd_meta), .wr_en(wr_en), .wr_bank(wr_bank),
      .wr_addr(wr_addr), .wr_key(wr_key), .wr_meta(wr_meta)
   );

   always_comb begin
      state_in = state_ff;
      func_in = func_ff; key_in = key_ff; len_in = len_ff;
      size_in = size_ff; cnt_in = cnt_ff; bank_in = bank_ff;
      idx_in = idx_ff; step_in = step_ff;
      tomb_ok_in = tomb_ok_ff; tomb_in = tomb_ff;
      scan_in = scan_ff; gkey_in = gkey_ff; glen_in = glen_ff;
      ok_in = ok_ff; full_in = full_ff; rv_in = rv_ff;
      rok_in = rok_ff; rfull_in = rfull_ff;
      hreq = '{start: 1'b0, key: key_ff, len: len_ff, mult: mult_ff};
      rd_addr = idx_ff;
      wr_en = 1'b0; wr_bank = bank_ff; wr_addr = idx_ff;
      wr_key = key_ff; wr_meta = '{len: len_ff, status: ST_LIVE};
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            wr_addr = AW'(scan_ff);
            wr_meta = '{len: 4'd0, status: ST_EMPTY};
            scan_in = scan_ff + SW'(1);
            if (scan_ff + SW'(1) == SW'(StartSlots)) begin
               scan_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               key_in = req_key_chars & key_mask;
               len_in = len_sat;
               if (req_func == FUNC_ADD && size_ff < SW'(MaxSlots) &&
                   ({cnt_ff, 2'b00} >= CW'({size_ff, 1'b0} + {1'b0, size_ff}))) begin
                  scan_in = '0;
                  state_in = S_GCLR;
               end else begin
                  hreq = '{start: 1'b1, key: req_key_chars & key_mask, len: len_sat,
                           mult: mult_ff};
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            if (hdone) begin
               idx_in = AW'(hval[AW-1:0] & 64'(size_mask));
               step_in = SW'(1);
               tomb_ok_in = 1'b0;
               state_in = S_PRD;
            end
         end
         S_PRD: state_in = S_PCHK;
         S_PCHK: begin
            if (rd_meta.status == ST_LIVE && rd_meta.len == len_ff && rd_key == key_ff) begin
               ok_in = (func_ff == FUNC_CHECK) || (func_ff == FUNC_DEL);
               full_in = 1'b0;
               if (func_ff == FUNC_DEL) begin
                  wr_en = 1'b1;
                  wr_meta = '{len: 4'd0, status: ST_TOMB};
               end
               state_in = S_RESP;
            end else if (rd_meta.status == ST_EMPTY || step_ff == size_ff) begin
               ok_in = 1'b0; full_in = 1'b0;
               if (func_ff == FUNC_ADD) begin
                  if (tomb_ok_ff || rd_meta.status == ST_EMPTY ||
                      (rd_meta.status == ST_TOMB)) begin
                     wr_en = 1'b1;
                     wr_addr = tomb_ok_ff ? tomb_ff : idx_ff;
                     ok_in = 1'b1;
                     if (cnt_ff < SW'(MaxSlots)) cnt_in = cnt_ff + SW'(1);
                  end else begin
                     full_in = 1'b1;
                  end
               end
               state_in = S_RESP;
            end else begin
               if (rd_meta.status == ST_TOMB && !tomb_ok_ff) begin
                  tomb_ok_in = 1'b1; tomb_in = idx_ff;
               end
               idx_in = AW'(nxt_idx);
               step_in = step_ff + SW'(1);
               state_in = S_PRD;
            end
         end
         S_GCLR: begin
            wr_en = 1'b1; wr_bank = ~bank_ff;
            wr_addr = AW'(scan_ff);
            wr_meta = '{len: 4'd0, status: ST_EMPTY};
            scan_in = scan_ff + SW'(1);
            if (scan_ff + SW'(1) == nsize) begin
               scan_in = '0;
               state_in = S_GRD;
            end
         end
         S_GRD: begin
            rd_addr = AW'(scan_ff);
            state_in = S_GCHK;
         end
         S_GCHK: begin
            if (rd_meta.status == ST_LIVE) begin
               gkey_in = rd_key; glen_in = rd_meta.len;
               hreq = '{start: 1'b1, key: rd_key, len: rd_meta.len, mult: mult_ff};
               state_in = S_GHASH;
            end else begin
               scan_in = scan_ff + SW'(1);
               state_in = (scan_ff + SW'(1) == size_ff) ? S_DONE : S_GRD;
            end
         end
         S_GHASH: begin
            if (hdone) begin
               idx_in = AW'(hval[AW-1:0] & 64'(size_mask));
               step_in = SW'(1);
               state_in = S_GPRD;
            end
         end
         S_GPRD: begin
            state_in = S_GPCHK;
         end
         S_GPCHK: begin
            if (rd_meta.status == ST_EMPTY) begin
               wr_en = 1'b1; wr_bank = ~bank_ff;
               wr_key = gkey_ff; wr_meta = '{len: glen_ff, status: ST_LIVE};
               scan_in = scan_ff + SW'(1);
               state_in = (scan_ff + SW'(1) == size_ff) ? S_DONE : S_GRD;
            end else begin
               idx_in = AW'(nxt_idx);
               step_in = step_ff + SW'(1);
               state_in = S_GPRD;
            end
         end
         S_DONE: begin
            bank_in = ~bank_ff;
            size_in = nsize;
            hreq = '{start: 1'b1, key: key_ff, len: len_ff, mult: mult_ff};
            state_in = S_HASH;
         end
         S_RESP: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               rok_in = ok_ff;
               rfull_in = full_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         mult_ff <= MultReset;
         size_ff <= SW'(StartSlots);
         cnt_ff <= '0;
         bank_ff <= 1'b0;
         scan_ff <= '0;
         rv_ff <= 1'b0;
         rok_ff <= 1'b0;
         rfull_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) mult_ff <= csr_hash_multiplier;
         size_ff <= size_in;
         cnt_ff <= cnt_in;
         bank_ff <= bank_in;
         scan_ff <= scan_in;
         rv_ff <= rv_in;
         rok_ff <= rok_in;
         rfull_ff <= rfull_in;
      end
      func_ff <= func_in; key_ff <= key_in; len_ff <= len_in;
      idx_ff <= idx_in; step_ff <= step_in;
      tomb_ok_ff <= tomb_ok_in; tomb_ff <= tomb_in;
      gkey_ff <= gkey_in; glen_ff <= glen_in;
      ok_ff <= ok_in; full_ff <= full_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped under stall");
   assert property (@(posedge clock) disable iff (reset)
      !(rsp_ok && rsp_table_full))
      else $error("ok and full both set");
   assert property (@(posedge clock) disable iff (reset)
      size_ff <= SW'(MaxSlots))
      else $error("table size beyond maximum");
   assert property (@(posedge clock) disable iff (reset)
      rd_spare |-> !wr_en)
      else $error("write during spare read");

endmodule

// File: test/tb_string_hash_set_open_addressing.sv
// Self-checking testbench for the open-addressed string hash set with triangular probing.
module tb_string_hash_set_open_addressing;
   import shs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSlots = MaxSlotsDefault;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [3:0]  len;
   } lookup_type;

   typedef struct packed {
      logic ok;
      logic full;
   } verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_ADD;
   logic [63:0] req_key_chars = '0;
   logic [3:0]  req_key_length = 4'd1;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_ok;
   logic        rsp_table_full;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_hash_multiplier = 8'd0;

   lookup_type  pending_lookups[$];
   verdict_type due_verdicts[$];
   logic [63:0] set_key[NumSlots];
   meta_type    set_meta[NumSlots];
   logic [63:0] grow_key[NumSlots];
   meta_type    grow_meta[NumSlots];
   int          set_size;
   int          set_adds;
   logic [7:0]  set_mult;
   int          error_count = 0;
   int          csr_writes = 0;
   int          cycle_count = 0;
   int          req_gap = 0;
   int          rsp_gap = 0;
   logic        req_taken = 0;
   logic        calm = 0;

   string_hash_set_open_addressing DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] horner(logic [63:0] key, int len);
      logic [63:0] h;
      h = '0;
      for (int i = 0; i < len; i++) begin
         h = h * {56'd0, set_mult} + {56'd0, key[8*i +: 8]};
      end
      return h;
   endfunction

   function automatic logic probe_path(logic [63:0] key, int len, output int hit,
                                       output logic tomb_ok, output int tomb,
                                       output logic empty_ok, output int empty);
      int idx;
      idx = int'(horner(key, len) % set_size);
      hit = 0;
      tomb = 0;
      empty = 0;
      tomb_ok = 0;
      empty_ok = 0;
      for (int i = 0; i < set_size; i++) begin
         if (i > 0) begin
            idx = (idx + i) % set_size;
         end
         if (set_meta[idx].status == ST_LIVE && set_meta[idx].len == len
             && set_key[idx] == key) begin
            hit = idx;
            return 1;
         end
         if (set_meta[idx].status == ST_TOMB && !tomb_ok) begin
            tomb_ok = 1;
            tomb = idx;
         end
         if (set_meta[idx].status == ST_EMPTY) begin
            empty_ok = 1;
            empty = idx;
            return 0;
         end
      end
      return 0;
   endfunction

   function automatic void double_table();
      int nsize;
      int idx;
      nsize = (set_size * 2 > NumSlots) ? NumSlots : set_size * 2;
      for (int s = 0; s < NumSlots; s++) begin
         grow_meta[s] = '{len: 4'd0, status: ST_EMPTY};
      end
      for (int s = 0; s < set_size; s++) begin
         if (set_meta[s].status == ST_LIVE) begin
            idx = int'(horner(set_key[s], set_meta[s].len) % nsize);
            for (int i = 0; i < nsize; i++) begin
               if (i > 0) begin
                  idx = (idx + i) % nsize;
               end
               if (grow_meta[idx].status == ST_EMPTY) begin
                  grow_key[idx] = set_key[s];
                  grow_meta[idx] = '{len: set_meta[s].len, status: ST_LIVE};
                  break;
               end
            end
         end
      end
      set_key = grow_key;
      set_meta = grow_meta;
      set_size = nsize;
   endfunction

   function automatic verdict_type apply_lookup(lookup_type op);
      verdict_type v;
      int len;
      int hit, tomb, empty;
      logic tomb_ok, empty_ok, found;
      logic [63:0] key;
      v = '0;
      len = (op.len > 8) ? 8 : int'(op.len);
      key = (len >= 8) ? op.key : op.key & ((64'd1 << (8 * len)) - 64'd1);
      if (op.func == FUNC_ADD) begin
         if (set_size < NumSlots && 4 * set_adds >= 3 * set_size) begin
            double_table();
         end
         found = probe_path(key, len, hit, tomb_ok, tomb, empty_ok, empty);
         if (!found) begin
            if (tomb_ok || empty_ok) begin
               hit = tomb_ok ? tomb : empty;
               set_key[hit] = key;
               set_meta[hit] = '{len: 4'(len), status: ST_LIVE};
               if (set_adds < NumSlots) begin
                  set_adds++;
               end
               v.ok = 1;
            end else begin
               v.full = 1;
            end
         end
      end else if (op.func == FUNC_CHECK) begin
         v.ok = probe_path(key, len, hit, tomb_ok, tomb, empty_ok, empty);
      end else if (op.func == FUNC_DEL) begin
         if (probe_path(key, len, hit, tomb_ok, tomb, empty_ok, empty)) begin
            set_meta[hit] = '{len: 4'd0, status: ST_TOMB};
            v.ok = 1;
         end
      end
      return v;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 10000000) begin
         $display("%0t: timeout", $time);
         $display("tb_string_hash_set_open_addressing: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         set_size = StartSlotsDefault;
         set_adds = 0;
         set_mult = MultReset;
         for (int s = 0; s < NumSlots; s++) begin
            set_key[s] = '0;
            set_meta[s] = '{len: 4'd0, status: ST_EMPTY};
         end
         req_taken <= 0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            set_mult = csr_hash_multiplier;
            csr_writes <= csr_writes + 1;
         end
         if (req_valid && !req_stall) begin
            due_verdicts.push_back(apply_lookup('{func: req_func, key: req_key_chars,
                                                  len: req_key_length}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_verdicts.size() == 0) begin
               $display("%0t: unexpected transaction ok=%0b full=%0b", $time,
                        rsp_ok, rsp_table_full);
               error_count++;
            end else begin
               want = due_verdicts.pop_front();
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok expected %0b actual %0b", $time, want.ok, rsp_ok);
                  error_count++;
               end
               if (rsp_table_full !== want.full) begin
                  $display("%0t: table_full expected %0b actual %0b", $time, want.full,
                           rsp_table_full);
                  error_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      lookup_type op;
      if (!reset) begin
         if (req_valid && !req_taken) begin
            req_valid <= 1;
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 0;
         end else if (pending_lookups.size() > 0) begin
            op = pending_lookups.pop_front();
            req_func <= op.func;
            req_key_chars <= op.key;
            req_key_length <= op.len;
            req_valid <= 1;
            if (!calm && $urandom_range(0, 9) == 0) begin
               req_gap = $urandom_range(1, 14);
            end
         end else begin
            req_valid <= 0;
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
            if (!calm && $urandom_range(0, 11) == 0) begin
               rsp_gap = $urandom_range(1, 14);
            end
         end
      end
   end

   task automatic drain();
      while (pending_lookups.size() > 0 || req_valid || due_verdicts.size() > 0) begin
         @(negedge clock);
      end
      repeat (20) @(negedge clock);
   endtask

   task automatic write_mult(logic [7:0] value);
      int seen;
      @(negedge clock);
      seen = csr_writes;
      csr_hash_multiplier <= value;
      csr_valid <= 1;
      while (csr_writes == seen) begin
         @(negedge clock);
      end
      csr_valid <= 0;
   endtask

   task automatic queue_lookup(logic [1:0] func, logic [63:0] key, logic [3:0] len);
      pending_lookups.push_back('{func: func, key: key, len: len});
   endtask

   function automatic logic [63:0] short_key();
      logic [63:0] k;
      k = '0;
      for (int i = 0; i < 8; i++) begin
         k[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
      end
      if ($urandom_range(0, 4) != 0) begin
         k[63:24] = '0;
      end else begin
         k[63:24] = 40'({$urandom, $urandom});
      end
      return k;
   endfunction

   task automatic queue_mix(int count);
      int pick;
      logic [1:0] func;
      logic [3:0] len;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         func = (pick < 45) ? FUNC_ADD : (pick < 75) ? FUNC_CHECK :
                (pick < 95) ? FUNC_DEL : FUNC_NONE;
         len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(1, 3));
         queue_lookup(func, short_key(), len);
      end
   endtask

   task automatic queue_fill(int first, int count);
      logic [63:0] k;
      for (int n = first; n < first + count; n++) begin
         k = {$urandom, $urandom};
         k[15:0] = 16'(n);
         k[23:16] = 8'hFF;
         queue_lookup(FUNC_ADD, k, 4'd8);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      write_mult(8'd1);
      queue_lookup(FUNC_ADD, 64'h61, 4'd1);
      queue_lookup(FUNC_CHECK, 64'h61, 4'd1);
      queue_lookup(FUNC_ADD, 64'h61, 4'd1);
      queue_lookup(FUNC_DEL, 64'h61, 4'd1);
      queue_lookup(FUNC_DEL, 64'h61, 4'd1);
      queue_lookup(FUNC_CHECK, 64'h61, 4'd1);
      queue_lookup(FUNC_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      queue_lookup(FUNC_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      queue_lookup(FUNC_ADD, 64'hAAAA_5555_AA63_6261, 4'd3);
      queue_lookup(FUNC_CHECK, 64'h0000_0000_0063_6261, 4'd3);
      queue_lookup(FUNC_ADD, 64'h1234, 4'd0);
      queue_lookup(FUNC_CHECK, 64'h0, 4'd0);
      queue_lookup(FUNC_ADD, 64'h0, 4'd8);
      queue_lookup(FUNC_ADD, 64'h0102_0304_0506_0708, 4'd15);
      queue_lookup(FUNC_CHECK, 64'h0102_0304_0506_0708, 4'd8);
      queue_lookup(FUNC_NONE, 64'h61, 4'd1);
      queue_lookup(FUNC_CHECK, 64'h61, 4'd2);
      queue_lookup(FUNC_ADD, 64'h6261, 4'd2);
      queue_lookup(FUNC_ADD, 64'h6361, 4'd2);
      queue_lookup(FUNC_DEL, 64'h0, 4'd8);
      queue_lookup(FUNC_ADD, 64'h6461, 4'd2);
      drain();
      write_mult(8'd255);
      queue_mix(40);
      drain();
      write_mult(8'd0);
      queue_mix(20);
      drain();
      write_mult(MultReset);
      queue_fill(0, 700);
      while (pending_lookups.size() > 0) begin
         @(negedge clock);
      end
      calm = 1;
      queue_fill(700, 340);
      drain();
      repeat (50) @(negedge clock);
      if (error_count == 0) begin
         $display("tb_string_hash_set_open_addressing: clean");
      end else begin
         $display("tb_string_hash_set_open_addressing: errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/shs_pkg.sv
rtl/shs_hash.sv
rtl/shs_table.sv
rtl/string_hash_set_open_addressing.sv
test/tb_string_hash_set_open_addressing.sv
